@@ sv/text_console_glyph_renderer_assert.svh @@
// Assertion macros for the text console glyph renderer checker.
// Used by sv/tcgr_checker.sv; needs no other file.
`ifndef TEXT_CONSOLE_GLYPH_RENDERER_ASSERT_SVH
`define TEXT_CONSOLE_GLYPH_RENDERER_ASSERT_SVH

// same-cycle implication
`define TCGR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tcgr assertion failed");

// next-cycle implication
`define TCGR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcgr assertion failed");

`endif

@@ sv/tcgr_pkg.sv @@
// Shared types, constants and helper functions of the text console glyph renderer.
// Used by every module of the block; depends on nothing.
package tcgr_pkg;

    localparam int MAX_WIDTH   = 4096;
    localparam int MAX_HEIGHT  = 4096;
    localparam int GLYPH_ROWS  = 16;
    localparam int CHAR_W      = 8;
    localparam int SCROLL_MARGIN = 10 * GLYPH_ROWS;

    localparam int POS_W    = 13;
    localparam int CODE_W   = 8;
    localparam int BITS_W   = 8;
    localparam int GROW_W   = 4;
    localparam int COLOR_W  = 32;
    localparam int CFG_AW   = 4;
    localparam int ROW_W    = $clog2(GLYPH_ROWS);
    localparam int ADDR_W   = CODE_W + ROW_W;
    localparam int GLYPH_DEPTH = 256 * GLYPH_ROWS;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [POS_W-1:0] CUR_MAX     = '1;
    localparam logic [POS_W-1:0] MAX_W_V     = POS_W'(MAX_WIDTH);
    localparam logic [POS_W-1:0] MAX_H_V     = POS_W'(MAX_HEIGHT);
    localparam logic [POS_W-1:0] GLYPH_STEP  = POS_W'(GLYPH_ROWS);
    localparam logic [POS_W-1:0] CHAR_STEP   = POS_W'(CHAR_W);
    localparam logic [POS_W-1:0] MARGIN_STEP = POS_W'(SCROLL_MARGIN);
    localparam logic [ROW_W-1:0] LAST_ROW    = ROW_W'(GLYPH_ROWS - 1);

    localparam logic [CODE_W-1:0] CODE_NL = 8'd10;
    localparam logic [CODE_W-1:0] CODE_CR = 8'd13;

    localparam logic [COLOR_W-1:0] TEXT_RESET = 32'hffff_ffff;
    localparam logic [COLOR_W-1:0] FILL_RESET = 32'h0000_0000;
    localparam logic [POS_W-1:0]   WIDTH_RESET  = 13'd640;
    localparam logic [POS_W-1:0]   HEIGHT_RESET = 13'd480;

    typedef enum logic [1:0] {
        KIND_PUT       = 2'd0,
        KIND_BACKSPACE = 2'd1,
        KIND_CLEAR     = 2'd2,
        KIND_LOAD      = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        OP_ROW    = 2'd0,
        OP_SCROLL = 2'd1,
        OP_CLEAR  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_TEXT   = 2'd2,
        REG_FILL   = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        CMD_DRAW,
        CMD_CLEAR,
        CMD_LOAD
    } cmd_kind_t;

    typedef enum logic [1:0] {
        SQ_IDLE,
        SQ_SCROLL,
        SQ_ROWS,
        SQ_CLEAR
    } seq_state_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic               scroll;
        logic               rows;
        logic               blank;
        logic [CODE_W-1:0]  code;
        logic [POS_W-1:0]   row;
        logic [POS_W-1:0]   col;
        logic [GROW_W-1:0]  grow;
        logic [BITS_W-1:0]  gbits;
    } cmd_t;

    typedef struct packed {
        op_t                op;
        logic [POS_W-1:0]   row_y;
        logic [POS_W-1:0]   col_x;
        logic               use_mem;
        logic               last;
    } res_t;

    function automatic logic [POS_W-1:0] cur_add(input logic [POS_W-1:0] v,
                                                 input logic [POS_W-1:0] d);
        logic [POS_W:0] s;
        s = {1'b0, v} + {1'b0, d};
        return s[POS_W] ? CUR_MAX : s[POS_W-1:0];
    endfunction

    function automatic logic [POS_W-1:0] cur_sub(input logic [POS_W-1:0] v,
                                                 input logic [POS_W-1:0] d);
        return (v >= d) ? (v - d) : '0;
    endfunction

endpackage

@@ sv/tcgr_front.sv @@
// Front end: accepts input transactions, keeps the text cursor, classifies each
// transaction into a command for the queue where one is needed. Depends on tcgr_pkg.
module tcgr_front
    import tcgr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         kind,
    input  logic [CODE_W-1:0]  char_code,
    input  logic               use_position,
    input  logic [POS_W-1:0]   pos_x,
    input  logic [POS_W-1:0]   pos_y,
    input  logic [GROW_W-1:0]  glyph_row,
    input  logic [BITS_W-1:0]  glyph_bits,
    input  logic [POS_W-1:0]   width_eff,
    input  logic [POS_W-1:0]   height_eff,
    input  logic               q_full,
    output logic               q_push,
    output cmd_t               q_data
);

    logic [POS_W-1:0] cursor_col_reg, cursor_col_next;
    logic [POS_W-1:0] cursor_row_reg, cursor_row_next;
    logic             accept;
    logic             has_cmd;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign q_push   = accept && has_cmd;

    always_comb
    begin
        logic [POS_W-1:0] c0, c1, c3;
        logic [POS_W-1:0] r0, r1, r2, r3;
        logic             wrap, scroll;
        logic             bs_top;
        logic [POS_W-1:0] bs_row, bs_col;

        q_data          = '0;
        has_cmd         = 1'b0;
        cursor_col_next = cursor_col_reg;
        cursor_row_next = cursor_row_reg;

        c0     = use_position ? pos_x : cursor_col_reg;
        r0     = use_position ? pos_y : cursor_row_reg;
        wrap   = ({1'b0, c0} + {1'b0, CHAR_STEP}) >= {1'b0, width_eff};
        c1     = wrap ? '0 : c0;
        r1     = wrap ? cur_add(r0, GLYPH_STEP) : r0;
        scroll = ({1'b0, r1} + {1'b0, MARGIN_STEP}) >= {1'b0, height_eff};
        r2     = scroll ? cur_sub(r1, GLYPH_STEP) : r1;
        c3     = '0;
        r3     = r2;

        bs_top = (cursor_col_reg == '0) && (cursor_row_reg < GLYPH_STEP);
        bs_row = (cursor_col_reg == '0) ? (cursor_row_reg - GLYPH_STEP) : cursor_row_reg;
        bs_col = cur_sub((cursor_col_reg == '0) ? width_eff : cursor_col_reg, CHAR_STEP);

        case (kind_t'(kind))
            KIND_PUT:
            begin
                q_data.kind   = CMD_DRAW;
                q_data.scroll = scroll;
                q_data.row    = r2;
                q_data.col    = c1;
                q_data.code   = char_code;
                if (char_code == CODE_NL)
                begin
                    c3 = '0;
                    r3 = cur_add(r2, GLYPH_STEP);
                end
                else if (char_code == CODE_CR)
                begin
                    c3 = '0;
                end
                else
                begin
                    q_data.rows = 1'b1;
                    c3 = cur_add(c1, CHAR_STEP);
                end
                has_cmd = scroll || q_data.rows;
                if (!use_position)
                begin
                    cursor_col_next = c3;
                    cursor_row_next = r3;
                end
            end
            KIND_BACKSPACE:
            begin
                if (!bs_top)
                begin
                    q_data.kind     = CMD_DRAW;
                    q_data.rows     = 1'b1;
                    q_data.blank    = 1'b1;
                    q_data.row      = bs_row;
                    q_data.col      = bs_col;
                    has_cmd         = 1'b1;
                    cursor_col_next = bs_col;
                    cursor_row_next = bs_row;
                end
            end
            KIND_CLEAR:
            begin
                q_data.kind     = CMD_CLEAR;
                has_cmd         = 1'b1;
                cursor_col_next = '0;
                cursor_row_next = '0;
            end
            KIND_LOAD:
            begin
                q_data.kind  = CMD_LOAD;
                q_data.code  = char_code;
                q_data.grow  = glyph_row;
                q_data.gbits = glyph_bits;
                has_cmd      = {2'b00, glyph_row} < 6'(GLYPH_ROWS);
            end
            default:
            begin
                has_cmd = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_col_reg <= '0;
            cursor_row_reg <= '0;
        end
        else if (accept)
        begin
            cursor_col_reg <= cursor_col_next;
            cursor_row_reg <= cursor_row_next;
        end
    end

endmodule

@@ sv/tcgr_cmdq.sv @@
// Command queue between front end and back end, QUEUE_DEPTH entries.
// Depends on tcgr_pkg.
module tcgr_cmdq
    import tcgr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_data,
    input  logic pop,
    output cmd_t head,
    output logic full,
    output logic empty
);

    cmd_t               entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]    count_reg, count_next;

    assign full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ sv/tcgr_back.sv @@
// Back end: sequences queued commands into result transactions, owns the glyph
// store memory and the output register. Depends on tcgr_pkg.
module tcgr_back
    import tcgr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  cmd_t                q_head,
    output logic                q_pop,
    input  logic [COLOR_W-1:0]  text_color,
    input  logic [COLOR_W-1:0]  fill_color,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [1:0]          op,
    output logic [POS_W-1:0]    row_y,
    output logic [POS_W-1:0]    col_x,
    output logic [BITS_W-1:0]   row_pattern,
    output logic [COLOR_W-1:0]  fore,
    output logic [COLOR_W-1:0]  back,
    output logic                last
);

    logic [BITS_W-1:0] glyph_mem [GLYPH_DEPTH];
    logic [BITS_W-1:0] rdata_reg;

    seq_state_t        state_reg, state_next;
    cmd_t              cur_reg;
    logic [ROW_W-1:0]  cnt_reg;

    logic              b_valid_reg;
    res_t              b_res_reg;

    logic              out_valid_reg;
    logic [1:0]        op_reg;
    logic [POS_W-1:0]  row_y_reg, col_x_reg;
    logic [BITS_W-1:0] pattern_reg;
    logic [COLOR_W-1:0] fore_reg, back_reg;
    logic              last_reg;

    logic              out_load, b_adv, issue_ok, issue;
    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    res_t              res;

    assign out_load = !out_valid_reg || !out_stall;
    assign b_adv    = b_valid_reg && out_load;
    assign issue_ok = !b_valid_reg || b_adv;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            SQ_IDLE:
            begin
                if (!q_empty)
                begin
                    case (q_head.kind)
                        CMD_DRAW:
                        begin
                            if (q_head.scroll)
                            begin
                                state_next = SQ_SCROLL;
                            end
                            else if (q_head.rows)
                            begin
                                state_next = SQ_ROWS;
                            end
                        end
                        CMD_CLEAR: state_next = SQ_CLEAR;
                        default:   state_next = SQ_IDLE;
                    endcase
                end
            end
            SQ_SCROLL:
            begin
                if (issue_ok)
                begin
                    state_next = cur_reg.rows ? SQ_ROWS : SQ_IDLE;
                end
            end
            SQ_ROWS:
            begin
                if (issue_ok && (cnt_reg == LAST_ROW))
                begin
                    state_next = SQ_IDLE;
                end
            end
            SQ_CLEAR:
            begin
                if (issue_ok)
                begin
                    state_next = SQ_IDLE;
                end
            end
            default: state_next = SQ_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop     = 1'b0;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        issue     = 1'b0;
        res       = '0;
        mem_waddr = {q_head.code, q_head.grow[ROW_W-1:0]};
        mem_raddr = {cur_reg.code, cnt_reg};
        case (state_reg)
            SQ_IDLE:
            begin
                q_pop  = !q_empty;
                mem_we = !q_empty && (q_head.kind == CMD_LOAD);
            end
            SQ_SCROLL:
            begin
                issue    = issue_ok;
                res.op   = OP_SCROLL;
                res.last = !cur_reg.rows;
            end
            SQ_ROWS:
            begin
                issue       = issue_ok;
                mem_re      = issue_ok && !cur_reg.blank;
                res.op      = OP_ROW;
                res.row_y   = cur_reg.row + POS_W'(cnt_reg);
                res.col_x   = cur_reg.col;
                res.use_mem = !cur_reg.blank;
                res.last    = (cnt_reg == LAST_ROW);
            end
            SQ_CLEAR:
            begin
                issue    = issue_ok;
                res.op   = OP_CLEAR;
                res.last = 1'b1;
            end
            default:
            begin
                issue = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            glyph_mem[mem_waddr] <= q_head.gbits;
        end
        if (mem_re)
        begin
            rdata_reg <= glyph_mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= SQ_IDLE;
            cnt_reg       <= '0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (q_pop)
            begin
                cnt_reg <= '0;
            end
            else if (issue && (state_reg == SQ_ROWS))
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (issue_ok)
            begin
                b_valid_reg <= issue;
            end
            if (out_load)
            begin
                out_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_head;
        end
        if (issue)
        begin
            b_res_reg <= res;
        end
        if (b_adv)
        begin
            op_reg      <= b_res_reg.op;
            row_y_reg   <= b_res_reg.row_y;
            col_x_reg   <= b_res_reg.col_x;
            pattern_reg <= b_res_reg.use_mem ? rdata_reg : '0;
            fore_reg    <= (b_res_reg.op == OP_ROW) ? text_color : '0;
            back_reg    <= fill_color;
            last_reg    <= b_res_reg.last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign op          = op_reg;
    assign row_y       = row_y_reg;
    assign col_x       = col_x_reg;
    assign row_pattern = pattern_reg;
    assign fore        = fore_reg;
    assign back        = back_reg;
    assign last        = last_reg;

endmodule

@@ sv/text_console_glyph_renderer.sv @@
// Top level of the text console glyph renderer: register port, front end,
// command queue and back end. Depends on tcgr_pkg, tcgr_front, tcgr_cmdq, tcgr_back.
//
//  channel   direction  handshake            payload
//  input     in         in_valid / in_stall  kind char_code use_position pos_x pos_y
//                                            glyph_row glyph_bits
//  output    out        out_valid/out_stall  op row_y col_x row_pattern fore back last
//  config    in         psel/penable/pready  paddr pwrite pwdata prdata
//
// Front end takes one transaction per cycle while the 4-entry command queue has room.
// Back end sequencer: dequeues when idle, then one result per cycle unless the output
// stalls; a character or backspace gives glyph rows, a clear one result, a load none.
// Results leave through a staging register and an output register; a stalled output
// holds both and the queue fills until in_stall rises.
// Reset clears cursor, queue, sequencer and registers; the glyph store is not cleared.
module text_console_glyph_renderer
    import tcgr_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [CFG_AW-1:0]   paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          kind,
    input  logic [CODE_W-1:0]   char_code,
    input  logic                use_position,
    input  logic [POS_W-1:0]    pos_x,
    input  logic [POS_W-1:0]    pos_y,
    input  logic [GROW_W-1:0]   glyph_row,
    input  logic [BITS_W-1:0]   glyph_bits,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [1:0]          op,
    output logic [POS_W-1:0]    row_y,
    output logic [POS_W-1:0]    col_x,
    output logic [BITS_W-1:0]   row_pattern,
    output logic [COLOR_W-1:0]  fore,
    output logic [COLOR_W-1:0]  back,
    output logic                last
);

    logic [POS_W-1:0]   screen_width_reg, screen_height_reg;
    logic [COLOR_W-1:0] text_color_reg, fill_color_reg;
    logic [POS_W-1:0]   width_eff, height_eff;
    logic               cfg_we;
    reg_idx_t           cfg_idx;

    logic               q_push, q_pop, q_full, q_empty;
    cmd_t               q_data, q_head;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_width_reg  <= WIDTH_RESET;
            screen_height_reg <= HEIGHT_RESET;
            text_color_reg    <= TEXT_RESET;
            fill_color_reg    <= FILL_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                REG_WIDTH:  screen_width_reg  <= pwdata[POS_W-1:0];
                REG_HEIGHT: screen_height_reg <= pwdata[POS_W-1:0];
                REG_TEXT:   text_color_reg    <= pwdata;
                REG_FILL:   fill_color_reg    <= pwdata;
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_WIDTH:  prdata = 32'(screen_width_reg);
            REG_HEIGHT: prdata = 32'(screen_height_reg);
            REG_TEXT:   prdata = text_color_reg;
            REG_FILL:   prdata = fill_color_reg;
            default:    prdata = '0;
        endcase
    end

    assign width_eff  = (screen_width_reg > MAX_W_V) ? MAX_W_V : screen_width_reg;
    assign height_eff = (screen_height_reg > MAX_H_V) ? MAX_H_V : screen_height_reg;

    tcgr_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .char_code    (char_code),
        .use_position (use_position),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .glyph_row    (glyph_row),
        .glyph_bits   (glyph_bits),
        .width_eff    (width_eff),
        .height_eff   (height_eff),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_data       (q_data)
    );

    tcgr_cmdq u_cmdq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_data),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    tcgr_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .text_color  (text_color_reg),
        .fill_color  (fill_color_reg),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .op          (op),
        .row_y       (row_y),
        .col_x       (col_x),
        .row_pattern (row_pattern),
        .fore        (fore),
        .back        (back),
        .last        (last)
    );

endmodule

@@ sv/tcgr_checker.sv @@
// Port-level checker for the text console glyph renderer, bound to the top level.
// Depends on tcgr_pkg and text_console_glyph_renderer_assert.svh.
`include "text_console_glyph_renderer_assert.svh"

module tcgr_checker
    import tcgr_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_stall,
    input logic [1:0]          op,
    input logic [POS_W-1:0]    row_y,
    input logic [POS_W-1:0]    col_x,
    input logic [BITS_W-1:0]   row_pattern,
    input logic [COLOR_W-1:0]  fore,
    input logic                last
);

    `TCGR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)

    `TCGR_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(row_y) && $stable(col_x) && $stable(row_pattern) && $stable(last))

    `TCGR_ASSERT_NOW(a_req_zero, clk, rst_n, out_valid && (op != OP_ROW), (row_y == '0) && (col_x == '0) && (row_pattern == '0) && (fore == '0))

    `TCGR_ASSERT_NOW(a_clear_last, clk, rst_n, out_valid && (op == OP_CLEAR), last)

endmodule

bind text_console_glyph_renderer tcgr_checker u_tcgr_checker (.*);
